### sv/cscol_pkg.sv
// Package with widths, types and shared constants for the circle collision test.
`default_nettype none
package cscol_pkg;

  localparam int CoordW = 24;
  localparam int LenW   = 23;
  localparam int DiffW  = 26;
  localparam int SqW    = 52;
  localparam int RootW  = 26;
  localparam int PenW   = 25;
  localparam int NormW  = 16;
  localparam int QuoW   = 16;
  localparam int DivNumW = 41;
  localparam int DivStages = QuoW;
  localparam logic signed [NormW-1:0] Q14One = 16'sd16384;
  localparam logic signed [PenW+2:0] PenMax = 28'sd16777215;
  localparam logic signed [PenW+2:0] PenMin = -28'sd16777216;

  // Per-transaction control travelling alongside the arithmetic.
  typedef struct packed {
    logic hit;
    logic zero_len;
    logic negate;
    logic neg_x;
    logic neg_y;
    logic signed [PenW+2:0] rad;
  } cscol_ctl_t;

  typedef struct packed {
    logic [DiffW-1:0] ax;
    logic [DiffW-1:0] ay;
  } cscol_vec_t;

endpackage
`default_nettype wire

### sv/cscol_geom.sv
// Geometry front end: offsets, box clamping and squared lengths over three stages.
`default_nettype none
module cscol_geom import cscol_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     adv,
  input  wire logic                     in_vld,
  input  wire logic                     cmd,
  input  wire logic signed [CoordW-1:0] center_x,
  input  wire logic signed [CoordW-1:0] center_y,
  input  wire logic [LenW-1:0]          circle_radius,
  input  wire logic signed [CoordW-1:0] other_x,
  input  wire logic signed [CoordW-1:0] other_y,
  input  wire logic [LenW-1:0]          other_radius,
  input  wire logic [LenW-1:0]          box_width,
  input  wire logic [LenW-1:0]          box_height,
  output logic                          out_vld,
  output logic [SqW-1:0]                sq,
  output cscol_vec_t                    vec,
  output cscol_ctl_t                    ctl
);

  // Stage 1: offsets and half extents.
  logic                   v1_r;
  logic                   box1_r;
  logic signed [DiffW-1:0] dx1_r, dy1_r;
  logic [LenW-1:0]        hx1_r, hy1_r, r1_1_r;
  logic [LenW:0]          rs1_r;

  // Stage 2: contact vector.
  logic                   v2_r;
  logic signed [DiffW-1:0] vx2_r, vy2_r;
  logic                   box2_r, inside2_r;
  logic [LenW-1:0]        r1_2_r;
  logic [LenW:0]          rs2_r;

  // Stage 3: squares.
  logic                   v3_r;
  logic [SqW-1:0]         sq3_r;
  logic [SqW-1:0]         rsq3_r;
  logic                   box3_r, inside3_r;
  logic signed [DiffW-1:0] vx3_r, vy3_r;
  logic [LenW-1:0]        r1_3_r;
  logic [LenW:0]          rs3_r;

  logic signed [DiffW-1:0] kx, ky, adx, ady;
  logic signed [DiffW-1:0] shx, shy;
  logic                   in_box;
  logic [DiffW-1:0]       ax3, ay3;
  logic                   hit3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      box1_r <= cmd;
      if (cmd) begin
        dx1_r <= DiffW'(center_x) - DiffW'(other_x);
        dy1_r <= DiffW'(center_y) - DiffW'(other_y);
      end else begin
        dx1_r <= DiffW'(other_x) - DiffW'(center_x);
        dy1_r <= DiffW'(other_y) - DiffW'(center_y);
      end
      hx1_r  <= box_width >> 1;
      hy1_r  <= box_height >> 1;
      r1_1_r <= circle_radius;
      rs1_r  <= {1'b0, circle_radius} + {1'b0, other_radius};
    end
  end

  always_comb begin
    shx = DiffW'(hx1_r);
    shy = DiffW'(hy1_r);
    kx = (dx1_r > shx) ? shx : ((dx1_r < -shx) ? -shx : dx1_r);
    ky = (dy1_r > shy) ? shy : ((dy1_r < -shy) ? -shy : dy1_r);
    in_box = (kx == dx1_r) && (ky == dy1_r);
    adx = dx1_r[DiffW-1] ? -dx1_r : dx1_r;
    ady = dy1_r[DiffW-1] ? -dy1_r : dy1_r;
    if (in_box) begin
      if (adx > ady) kx = (kx > 0) ? shx : -shx;
      else ky = (ky > 0) ? shy : -shy;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      box2_r    <= box1_r;
      inside2_r <= box1_r && in_box;
      vx2_r     <= box1_r ? dx1_r - kx : dx1_r;
      vy2_r     <= box1_r ? dy1_r - ky : dy1_r;
      r1_2_r    <= r1_1_r;
      rs2_r     <= rs1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq3_r     <= SqW'(vx2_r * vx2_r) + SqW'(vy2_r * vy2_r);
      rsq3_r    <= box2_r ? SqW'(r1_2_r) * SqW'(r1_2_r) : SqW'(rs2_r) * SqW'(rs2_r);
      box3_r    <= box2_r;
      inside3_r <= inside2_r;
      vx3_r     <= vx2_r;
      vy3_r     <= vy2_r;
      r1_3_r    <= r1_2_r;
      rs3_r     <= rs2_r;
    end
  end

  assign ax3  = vx3_r[DiffW-1] ? DiffW'(-vx3_r) : DiffW'(vx3_r);
  assign ay3  = vy3_r[DiffW-1] ? DiffW'(-vy3_r) : DiffW'(vy3_r);
  assign hit3 = inside3_r || (sq3_r <= rsq3_r);

  always_comb begin
    out_vld      = v3_r;
    sq           = sq3_r;
    vec.ax       = ax3;
    vec.ay       = ay3;
    ctl.hit      = hit3;
    ctl.zero_len = (sq3_r == '0);
    ctl.negate   = inside3_r;
    ctl.neg_x    = vx3_r[DiffW-1];
    ctl.neg_y    = vy3_r[DiffW-1];
    // Circle pair with coincident centres reports the first radius.
    if (!box3_r && sq3_r == '0) ctl.rad = (PenW+3)'(r1_3_r);
    else if (box3_r)            ctl.rad = (PenW+3)'(r1_3_r);
    else                        ctl.rad = (PenW+3)'(rs3_r);
  end

endmodule
`default_nettype wire

### sv/cscol_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module cscol_sqrt import cscol_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire logic            in_vld,
  input  wire logic [SqW-1:0]  rad_in,
  input  wire cscol_vec_t      vec_in,
  input  wire cscol_ctl_t      ctl_in,
  output logic                 out_vld,
  output logic [RootW-1:0]     root,
  output cscol_vec_t           vec_out,
  output cscol_ctl_t           ctl_out
);

  localparam int Steps = RootW;

  logic                   v_r    [Steps+1];
  logic [SqW-1:0]         rem_r  [Steps+1];
  logic [RootW-1:0]       res_r  [Steps+1];
  cscol_vec_t             vec_r  [Steps+1];
  cscol_ctl_t             ctl_r  [Steps+1];

  always_comb begin
    v_r[0]   = in_vld;
    rem_r[0] = rad_in;
    res_r[0] = '0;
    vec_r[0] = vec_in;
    ctl_r[0] = ctl_in;
  end

  // Restoring method: stage i decides root bit RootW-1-i.
  for (genvar i = 0; i < Steps; i++) begin : g_stage
    localparam int B = RootW - 1 - i;
    logic [SqW:0] trial;
    logic [RootW-1:0] cand;
    always_comb begin
      cand  = res_r[i] | (RootW'(1) << B);
      trial = (SqW+1)'(cand) * (SqW+1)'(cand);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i+1] <= 1'b0;
      else if (adv) v_r[i+1] <= v_r[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i+1] <= rem_r[i];
        res_r[i+1] <= (trial <= (SqW+1)'(rem_r[i])) ? cand : res_r[i];
        vec_r[i+1] <= vec_r[i];
        ctl_r[i+1] <= ctl_r[i];
      end
    end
  end

  assign out_vld = v_r[Steps];
  assign root    = res_r[Steps];
  assign vec_out = vec_r[Steps];
  assign ctl_out = ctl_r[Steps];

endmodule
`default_nettype wire

### sv/cscol_div.sv
// Pipelined normalizer: two restoring dividers giving rounded Q1.14 components.
`default_nettype none
module cscol_div import cscol_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              in_vld,
  input  wire logic [RootW-1:0]  root_in,
  input  wire cscol_vec_t        vec_in,
  input  wire cscol_ctl_t        ctl_in,
  output logic                   out_vld,
  output logic [QuoW-1:0]        qx,
  output logic [QuoW-1:0]        qy,
  output logic [RootW-1:0]       root_out,
  output cscol_ctl_t             ctl_out
);

  // Numerator = |c| * 16384 + len / 2; the quotient is clamped at 16384,
  // so 16 quotient bits suffice; a numerator of at least 2^16 * len is flagged and clamped.
  logic                  v_r  [DivStages+1];
  logic [DivNumW-1:0]    nx_r [DivStages+1];
  logic [DivNumW-1:0]    ny_r [DivStages+1];
  logic [QuoW-1:0]       qx_r [DivStages+1];
  logic [QuoW-1:0]       qy_r [DivStages+1];
  logic                  ovx_r [DivStages+1];
  logic                  ovy_r [DivStages+1];
  logic [RootW-1:0]      d_r  [DivStages+1];
  cscol_ctl_t            ctl_r [DivStages+1];

  logic [DivNumW-1:0] numx, numy;
  logic [DivNumW-1:0] lim;

  always_comb begin
    numx = (DivNumW'(vec_in.ax) << 14) + DivNumW'(root_in >> 1);
    numy = (DivNumW'(vec_in.ay) << 14) + DivNumW'(root_in >> 1);
    lim  = DivNumW'(root_in) << QuoW;
    v_r[0]   = in_vld;
    nx_r[0]  = numx;
    ny_r[0]  = numy;
    qx_r[0]  = '0;
    qy_r[0]  = '0;
    ovx_r[0] = numx >= lim;
    ovy_r[0] = numy >= lim;
    d_r[0]   = root_in;
    ctl_r[0] = ctl_in;
  end

  for (genvar i = 0; i < DivStages; i++) begin : g_stage
    localparam int B = QuoW - 1 - i;
    logic [DivNumW-1:0] sub;
    logic [DivNumW-1:0] nxx, nyy;
    logic               tx, ty;
    always_comb begin
      sub = DivNumW'(d_r[i]) << B;
      tx  = nx_r[i] >= sub;
      ty  = ny_r[i] >= sub;
      nxx = tx ? nx_r[i] - sub : nx_r[i];
      nyy = ty ? ny_r[i] - sub : ny_r[i];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i+1] <= 1'b0;
      else if (adv) v_r[i+1] <= v_r[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        nx_r[i+1]  <= nxx;
        ny_r[i+1]  <= nyy;
        qx_r[i+1]  <= qx_r[i] | (QuoW'(tx) << B);
        qy_r[i+1]  <= qy_r[i] | (QuoW'(ty) << B);
        ovx_r[i+1] <= ovx_r[i];
        ovy_r[i+1] <= ovy_r[i];
        d_r[i+1]   <= d_r[i];
        ctl_r[i+1] <= ctl_r[i];
      end
    end
  end

  always_comb begin
    qx = (ovx_r[DivStages] || qx_r[DivStages] > QuoW'(Q14One)) ? QuoW'(Q14One)
                                                                : qx_r[DivStages];
    qy = (ovy_r[DivStages] || qy_r[DivStages] > QuoW'(Q14One)) ? QuoW'(Q14One)
                                                                : qy_r[DivStages];
  end

  assign out_vld  = v_r[DivStages];
  assign root_out = d_r[DivStages];
  assign ctl_out  = ctl_r[DivStages];

endmodule
`default_nettype wire

### sv/circle_shape_collision_test_top.sv
// Top level of the circle versus circle or box collision test pipeline.
`default_nettype none
// Collision test for a circle against a second circle (cmd 0) or an axis-aligned
// box (cmd 1), in signed Q12.12 with a Q1.14 unit normal. The block is a fully
// pipelined datapath that accepts one transaction per clock cycle unless the
// output stalls, and returns exactly one result per transaction, in order. The
// path from acceptance to the presented result has 3 geometry stages, 26
// square-root stages (one root bit each), 16 divider stages (one quotient bit
// each) and one output stage. The output register holds a finished result
// while the consumer stalls; the whole pipe advances only when that register
// is free or being drained, so in_ready is simply the advance condition and
// nothing is lost or repeated. The normal of a touching pair with zero contact
// length is (1,0), and a miss returns zero penetration and a zero normal.
module circle_shape_collision_test_top import cscol_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_cmd,
  input  wire logic signed [CoordW-1:0] in_center_x,
  input  wire logic signed [CoordW-1:0] in_center_y,
  input  wire logic [LenW-1:0]          in_circle_radius,
  input  wire logic signed [CoordW-1:0] in_other_x,
  input  wire logic signed [CoordW-1:0] in_other_y,
  input  wire logic [LenW-1:0]          in_other_radius,
  input  wire logic [LenW-1:0]          in_box_width,
  input  wire logic [LenW-1:0]          in_box_height,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          out_hit,
  output logic signed [PenW-1:0]        out_penetration,
  output logic signed [NormW-1:0]       out_normal_x,
  output logic signed [NormW-1:0]       out_normal_y
);

  logic adv;
  logic g_vld, s_vld, d_vld;
  logic [SqW-1:0] g_sq;
  cscol_vec_t g_vec, s_vec;
  cscol_ctl_t g_ctl, s_ctl, d_ctl;
  logic [RootW-1:0] s_root, d_root;
  logic [QuoW-1:0] qx, qy;

  logic out_valid_r;
  logic hit_r;
  logic signed [PenW-1:0] pen_r;
  logic signed [NormW-1:0] nx_r, ny_r;

  logic signed [PenW+2:0] pen_full, pen_sat;
  logic signed [NormW-1:0] nx_nxt, ny_nxt;

  // The pipe moves whenever the output register can take a new value.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  cscol_geom u_geom (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(in_valid && adv),
    .cmd(in_cmd), .center_x(in_center_x), .center_y(in_center_y),
    .circle_radius(in_circle_radius), .other_x(in_other_x), .other_y(in_other_y),
    .other_radius(in_other_radius), .box_width(in_box_width),
    .box_height(in_box_height),
    .out_vld(g_vld), .sq(g_sq), .vec(g_vec), .ctl(g_ctl)
  );

  cscol_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(g_vld), .rad_in(g_sq),
    .vec_in(g_vec), .ctl_in(g_ctl),
    .out_vld(s_vld), .root(s_root), .vec_out(s_vec), .ctl_out(s_ctl)
  );

  cscol_div u_div (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(s_vld), .root_in(s_root),
    .vec_in(s_vec), .ctl_in(s_ctl),
    .out_vld(d_vld), .qx(qx), .qy(qy), .root_out(d_root), .ctl_out(d_ctl)
  );

  // Final assembly: penetration saturation and normal sign handling.
  always_comb begin
    pen_full = d_ctl.rad - (PenW+3)'(d_root);
    if (pen_full > PenMax)      pen_sat = PenMax;
    else if (pen_full < PenMin) pen_sat = PenMin;
    else                        pen_sat = pen_full;
    if (d_ctl.zero_len) begin
      nx_nxt = Q14One;
      ny_nxt = '0;
    end else begin
      nx_nxt = (d_ctl.neg_x ^ d_ctl.negate) ? -NormW'(qx) : NormW'(qx);
      ny_nxt = (d_ctl.neg_y ^ d_ctl.negate) ? -NormW'(qy) : NormW'(qy);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= d_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r <= d_ctl.hit;
      pen_r <= d_ctl.hit ? PenW'(pen_sat) : '0;
      nx_r  <= d_ctl.hit ? nx_nxt : '0;
      ny_r  <= d_ctl.hit ? ny_nxt : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = hit_r;
  assign out_penetration = pen_r;
  assign out_normal_x    = nx_r;
  assign out_normal_y    = ny_r;

  // A miss always carries a zero payload.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_penetration == '0 && out_normal_x == '0
                                 && out_normal_y == '0))
    else $error("miss result with nonzero payload");

  // A held result stays valid, with stable penetration and x normal, while the consumer stalls.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_penetration)
                                   && $stable(out_normal_x)))
    else $error("stalled result changed");

  // Ready only drops while a result is waiting.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");

endmodule
`default_nettype wire
